>>> design/skuc_pkg.sv
// Shared types, constants and constant tables of the soft-knee upward compressor.
package skuc_pkg;

	// Defaults of the top-level parameters
	localparam int CHANNELS_DEF    = 2;
	localparam int SAMPLE_BITS_DEF = 24;

	// Fixed widths
	localparam int CH_IDX_W   = 3;   // channel index, up to eight channels
	localparam int MAG_W      = 32;  // sample magnitude, up to 32-bit samples
	localparam int MSB_W      = 5;
	localparam int NORM_W     = 31;  // magnitude normalized to Q1.30
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int RATIO_W    = 13;
	localparam int DB_W       = 16;
	localparam int KNEE_W     = 13;
	localparam int COEFF_W    = 16;
	localparam int BOOST_W    = 15;

	// Register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RATIO   = 3'd0,
		REG_RANGE   = 3'd1,
		REG_KNEE    = 3'd2,
		REG_ATTACK  = 3'd3,
		REG_RELEASE = 3'd4
	} skuc_reg_t;

	// Register reset values
	localparam logic [RATIO_W-1:0] RATIO_RST   = 13'd512;
	localparam logic [DB_W-1:0]    RANGE_RST   = 16'hD800;  // -40 dB
	localparam logic [KNEE_W-1:0]  KNEE_RST    = 13'd1536;
	localparam logic [COEFF_W-1:0] ATTACK_RST  = 16'd65399;
	localparam logic [COEFF_W-1:0] RELEASE_RST = 16'd65522;

	// Arithmetic constants
	localparam logic [BOOST_W-1:0] DB_FLOOR   = 15'd25600;  // 100 dB in Q8.8
	localparam logic [31:0]        DB_PER_OCT = 32'd394566;  // 20*log10(2), Q16
	localparam logic [31:0]        OCT_PER_DB = 32'd2786635;

	// Integer square root, evaluated at elaboration only
	function automatic logic [63:0] isqrt64(input logic [63:0] x);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] b;
		v   = x;
		res = 64'd0;
		b   = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (b > v) begin
				b = b >> 2;
			end
		end
		for (int i = 0; i < 32; i++) begin
			if (b != 64'd0) begin
				if (v >= res + b) begin
					v   = v - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
		end
		return res;
	endfunction

	// 2^(2^-k) in Q30 by repeated square roots of 2
	function automatic logic [31:0] pow_entry(input int k);
		logic [63:0] p;
		p = 64'd1 << 31;
		for (int j = 1; j <= 16; j++) begin
			if (j <= k) begin
				p = isqrt64(p << 30);
			end
		end
		return p[31:0];
	endfunction

	localparam logic [31:0] POW_TAB [16] = '{
		pow_entry(1),  pow_entry(2),  pow_entry(3),  pow_entry(4),
		pow_entry(5),  pow_entry(6),  pow_entry(7),  pow_entry(8),
		pow_entry(9),  pow_entry(10), pow_entry(11), pow_entry(12),
		pow_entry(13), pow_entry(14), pow_entry(15), pow_entry(16)
	};

	// Configuration seen by the back end
	typedef struct packed {
		logic [RATIO_W-1:0] ratio_q8;
		logic [DB_W-1:0]    range_db;
		logic [KNEE_W-1:0]  knee_db;
		logic [COEFF_W-1:0] attack_coeff;
		logic [COEFF_W-1:0] release_coeff;
	} skuc_cfg_t;

	// Classified item passed from front to back
	typedef struct packed {
		logic [CH_IDX_W-1:0] ch;
		logic                neg;
		logic                zero;
		logic                full;
		logic [MSB_W-1:0]    msb;
		logic [MAG_W-1:0]    mag;
		logic [NORM_W-1:0]   norm;
	} skuc_item_t;

endpackage

>>> design/skuc_stream_if.sv
// Valid/ready stream interfaces for the compressor's input and output channels.
interface skuc_in_if import skuc_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic                          channel;
	logic signed [SAMPLE_BITS-1:0] sample_in;

	modport source (output valid, channel, sample_in, input ready);
	modport sink (input valid, channel, sample_in, output ready);
endinterface

interface skuc_out_if import skuc_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic [BOOST_W-1:0]            boost_db;

	modport source (output valid, sample_out, boost_db, input ready);
	modport sink (input valid, sample_out, boost_db, output ready);
endinterface

>>> design/skuc_front.sv
// Front end: accepts samples, takes the magnitude and normalizes it for the log unit.
module skuc_front import skuc_pkg::*; #(
	parameter int CHANNELS    = CHANNELS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	skuc_in_if.sink    upstream,
	input  logic       q_full,
	output logic       push,
	output skuc_item_t item
);

	logic [SAMPLE_BITS-1:0] raw;
	logic [SAMPLE_BITS-1:0] mag;
	logic [MSB_W-1:0]       msb;
	logic [63:0]            ext;
	logic [63:0]            shifted;
	logic                   zero;

	// Accept whenever the queue has room
	assign upstream.ready = !q_full;
	assign push           = upstream.valid && !q_full;

	// Magnitude and leading one
	always_comb begin
		raw = upstream.sample_in;
		mag = raw[SAMPLE_BITS-1] ? SAMPLE_BITS'(~raw + SAMPLE_BITS'(1)) : raw;
		msb = '0;
		for (int i = 0; i < SAMPLE_BITS; i++) begin
			if (mag[i]) begin
				msb = MSB_W'(i);
			end
		end
		zero = (mag == '0);
	end

	// Normalize to Q1.30
	always_comb begin
		ext = 64'(mag);
		if (msb <= 5'd30) begin
			shifted = ext << (5'd30 - msb);
		end else begin
			shifted = ext >> (msb - 5'd30);
		end
	end

	// Pack the classified item
	always_comb begin
		item.ch   = (CHANNELS == 1) ? '0 : CH_IDX_W'(upstream.channel);
		item.neg  = raw[SAMPLE_BITS-1];
		item.zero = zero;
		item.full = !zero && (6'(msb) >= 6'(SAMPLE_BITS - 1));
		item.msb  = msb;
		item.mag  = MAG_W'(mag);
		item.norm = shifted[NORM_W-1:0];
	end

endmodule

>>> design/skuc_queue.sv
// Two-entry queue that decouples the front end from the back end.
module skuc_queue import skuc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  skuc_item_t item_in,
	output logic       full,
	input  logic       pop,
	output logic       empty,
	output skuc_item_t item_out
);

	skuc_item_t  entry_q [2];
	logic        wptr_q;
	logic        rptr_q;
	logic [1:0]  count_q;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign item_out = entry_q[rptr_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= item_in;
		end
	end

endmodule

>>> design/skuc_back.sv
// Back end: log level, soft-knee target, envelope smoothing and gain on one shared multiplier.
module skuc_back import skuc_pkg::*; #(
	parameter int CHANNELS    = CHANNELS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  skuc_cfg_t   cfg,
	input  logic        empty,
	input  skuc_item_t  item,
	output logic        pop,
	skuc_out_if.source  downstream
);

	localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int NUM_W = 42;
	localparam int DEN_W = 29;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SQR, ST_LVL, ST_KNEE, ST_KNEE2, ST_KNEE3, ST_DIV, ST_CAP,
		ST_ENV1, ST_ENV2, ST_GAIN, ST_POW, ST_MAG, ST_ROUND
	} state_t;

	state_t                 state_q;
	skuc_item_t             item_q;
	logic [5:0]             cnt_q;
	logic [NORM_W-1:0]      y_q;
	logic [15:0]            frac_q;
	logic [15:0]            lev_q;
	logic [27:0]            p_q;
	logic [NUM_W-1:0]       num_q;
	logic [DEN_W-1:0]       den_q;
	logic [DEN_W-1:0]       rem_q;
	logic [BOOST_W-1:0]     tgt_q;
	logic [COEFF_W-1:0]     coef_q;
	logic [31:0]            acc_q;
	logic [BOOST_W-1:0]     env_q;
	logic [BOOST_W-1:0]     env_mem_q [CHANNELS];
	logic [4:0]             ipart_q;
	logic [15:0]            gfrac_q;
	logic [31:0]            mult_q;
	logic [63:0]            mag_q;
	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] out_sample_q;
	logic [BOOST_W-1:0]     out_boost_q;

	logic [31:0]            mul_a;
	logic [31:0]            mul_b;
	logic [63:0]            prod;
	logic [31:0]            sq_t;
	logic [4:0]             oct;
	logic [20:0]            neg_val;
	logic [40:0]            lvl_round;
	logic [16:0]            lvl_mag;
	logic [BOOST_W-1:0]     lvl_cap;
	logic [RATIO_W-1:0]     ratio_eff;
	logic [RATIO_W-1:0]     ratio_m;
	logic signed [18:0]     l2_s;
	logic signed [18:0]     r2_s;
	logic signed [18:0]     knee_s;
	logic signed [18:0]     start2_s;
	logic signed [18:0]     end2_s;
	logic signed [18:0]     x2_s;
	logic [16:0]            diff_v;
	logic                   br_a;
	logic                   br_b;
	logic [DEN_W:0]         rem_sh;
	logic                   rem_ge;
	logic [DEN_W:0]         rem_sub;
	logic [BOOST_W-1:0]     env_old;
	logic [COEFF_W-1:0]     coef_sel;
	logic [33:0]            env_sum;
	logic [37:0]            g_round;
	logic [63:0]            pow_round;
	logic [4:0]             sh_v;
	logic [63:0]            rnd_v;
	logic [63:0]            r_v;
	logic [63:0]            full_v;
	logic [63:0]            sat_v;
	logic                   out_free;
	logic                   out_load;

	assign pop      = (state_q == ST_IDLE) && !empty;
	assign out_free = !out_valid_q || downstream.ready;
	assign out_load = (state_q == ST_ROUND) && out_free;

	assign downstream.valid      = out_valid_q;
	assign downstream.sample_out = out_sample_q;
	assign downstream.boost_db   = out_boost_q;

	// Knee classification
	always_comb begin
		ratio_eff = (cfg.ratio_q8 < 13'd256) ? 13'd256 : cfg.ratio_q8;
		ratio_m   = ratio_eff - 13'd256;
		l2_s      = {{2{lev_q[15]}}, lev_q, 1'b0};
		r2_s      = {{2{cfg.range_db[15]}}, cfg.range_db, 1'b0};
		knee_s    = {6'b0, cfg.knee_db};
		start2_s  = r2_s - knee_s;
		end2_s    = r2_s + knee_s;
		x2_s      = end2_s - l2_s;
		diff_v    = {cfg.range_db[15], cfg.range_db} - {lev_q[15], lev_q};
		br_a      = (l2_s < start2_s);
		br_b      = !br_a && (l2_s < end2_s) && (cfg.knee_db != '0);
	end

	// Shared multiplier operand select
	always_comb begin
		unique case (state_q)
			ST_SQR: begin
				mul_a = 32'(y_q);
				mul_b = 32'(y_q);
			end
			ST_LVL: begin
				mul_a = 32'(neg_val);
				mul_b = DB_PER_OCT;
			end
			ST_KNEE: begin
				mul_a = br_a ? 32'(diff_v[15:0]) : 32'(x2_s[14:0]);
				mul_b = br_a ? 32'(ratio_m) : 32'(x2_s[14:0]);
			end
			ST_KNEE2: begin
				mul_a = 32'(p_q);
				mul_b = 32'(ratio_m);
			end
			ST_KNEE3: begin
				mul_a = 32'(cfg.knee_db);
				mul_b = 32'(ratio_eff);
			end
			ST_ENV1: begin
				mul_a = 32'(coef_sel);
				mul_b = 32'(env_old);
			end
			ST_ENV2: begin
				mul_a = 32'(17'h10000 - {1'b0, coef_q});
				mul_b = 32'(tgt_q);
			end
			ST_GAIN: begin
				mul_a = 32'(env_q);
				mul_b = OCT_PER_DB;
			end
			ST_POW: begin
				mul_a = mult_q;
				mul_b = POW_TAB[cnt_q[3:0]];
			end
			ST_MAG: begin
				mul_a = item_q.mag;
				mul_b = mult_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		prod = 64'(mul_a) * 64'(mul_b);
	end

	// Datapath around the product
	always_comb begin
		sq_t      = prod[61:30];
		oct       = 5'(SAMPLE_BITS - 1) - item_q.msb;
		neg_val   = {oct, 16'b0} - {5'b0, frac_q};
		lvl_round = prod[40:0] + 41'(1 << 23);
		lvl_mag   = lvl_round[40:24];
		lvl_cap   = (lvl_mag > 17'(DB_FLOOR)) ? DB_FLOOR : lvl_mag[BOOST_W-1:0];
		rem_sh    = {rem_q, num_q[NUM_W-1]};
		rem_ge    = (rem_sh >= {1'b0, den_q});
		rem_sub   = rem_sh - {1'b0, den_q};
		env_old   = env_mem_q[item_q.ch[CH_W-1:0]];
		coef_sel  = (tgt_q > env_old) ? cfg.attack_coeff : cfg.release_coeff;
		env_sum   = 34'(acc_q) + 34'(prod[32:0]) + 34'd32768;
		g_round   = prod[37:0] + 38'd32768;
		pow_round = prod + 64'(1 << 29);
		sh_v      = 5'd30 - ipart_q;
		rnd_v     = 64'd1 << (sh_v - 5'd1);
		r_v       = (mag_q + rnd_v) >> sh_v;
		full_v    = 64'd1 << (SAMPLE_BITS - 1);
		if (item_q.neg) begin
			sat_v = (r_v > full_v) ? full_v : r_v;
			sat_v = ~sat_v + 64'd1;
		end else begin
			sat_v = (r_v > full_v - 64'd1) ? (full_v - 64'd1) : r_v;
		end
	end

	// Sequencer, envelopes and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			item_q       <= '0;
			cnt_q        <= '0;
			y_q          <= '0;
			frac_q       <= '0;
			lev_q        <= '0;
			p_q          <= '0;
			num_q        <= '0;
			den_q        <= '0;
			rem_q        <= '0;
			tgt_q        <= '0;
			coef_q       <= '0;
			acc_q        <= '0;
			env_q        <= '0;
			ipart_q      <= '0;
			gfrac_q      <= '0;
			mult_q       <= '0;
			mag_q        <= '0;
			out_valid_q  <= 1'b0;
			out_sample_q <= '0;
			out_boost_q  <= '0;
			for (int c = 0; c < CHANNELS; c++) begin
				env_mem_q[c] <= '0;
			end
		end else begin
			// Load a new result, or drop the one taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && downstream.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!empty) begin
						item_q <= item;
						y_q    <= item.norm;
						frac_q <= '0;
						cnt_q  <= 6'd15;
						if (item.zero) begin
							lev_q   <= 16'(0) - {1'b0, DB_FLOOR};
							state_q <= ST_KNEE;
						end else if (item.full) begin
							lev_q   <= '0;
							state_q <= ST_KNEE;
						end else begin
							state_q <= ST_SQR;
						end
					end
				end
				ST_SQR: begin
					// One fraction bit of log2 per squaring
					frac_q <= {frac_q[14:0], sq_t[31]};
					y_q    <= sq_t[31] ? sq_t[31:1] : sq_t[30:0];
					if (cnt_q == '0) begin
						state_q <= ST_LVL;
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				ST_LVL: begin
					lev_q   <= 16'(0) - {1'b0, lvl_cap};
					state_q <= ST_KNEE;
				end
				ST_KNEE: begin
					rem_q <= '0;
					cnt_q <= 6'(NUM_W - 1);
					if (br_a) begin
						num_q   <= NUM_W'(prod[28:0]);
						den_q   <= DEN_W'(ratio_eff);
						state_q <= ST_DIV;
					end else if (br_b) begin
						p_q     <= prod[27:0];
						state_q <= ST_KNEE2;
					end else begin
						num_q   <= '0;
						state_q <= ST_CAP;
					end
				end
				ST_KNEE2: begin
					num_q   <= prod[NUM_W-1:0];
					state_q <= ST_KNEE3;
				end
				ST_KNEE3: begin
					den_q   <= {prod[25:0], 3'b000};
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					// Restoring division, one quotient bit per cycle
					rem_q <= rem_ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
					num_q <= {num_q[NUM_W-2:0], rem_ge};
					if (cnt_q == '0) begin
						state_q <= ST_CAP;
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				ST_CAP: begin
					tgt_q   <= (num_q > NUM_W'(DB_FLOOR)) ? DB_FLOOR : num_q[BOOST_W-1:0];
					state_q <= ST_ENV1;
				end
				ST_ENV1: begin
					acc_q   <= prod[31:0];
					coef_q  <= coef_sel;
					state_q <= ST_ENV2;
				end
				ST_ENV2: begin
					env_q                         <= env_sum[30:16];
					env_mem_q[item_q.ch[CH_W-1:0]] <= env_sum[30:16];
					state_q                       <= ST_GAIN;
				end
				ST_GAIN: begin
					ipart_q <= g_round[36:32];
					gfrac_q <= g_round[31:16];
					mult_q  <= 32'd1 << 30;
					cnt_q   <= '0;
					state_q <= ST_POW;
				end
				ST_POW: begin
					// Apply 2^(2^-k) where the gain fraction bit is set
					if (gfrac_q[~cnt_q[3:0]]) begin
						mult_q <= pow_round[61:30];
					end
					if (cnt_q[3:0] == 4'd15) begin
						state_q <= ST_MAG;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_MAG: begin
					mag_q   <= prod;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					// Hold until the output register is free
					if (out_free) begin
						out_sample_q <= sat_v[SAMPLE_BITS-1:0];
						out_boost_q  <= env_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < den_q))
		else $error("divider remainder not below divisor");

	a_env_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ENV2) |-> (env_sum[33:16] <= 18'(DB_FLOOR)))
		else $error("envelope above 100 dB");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && out_free) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("result not loaded into output register");
`endif

endmodule

>>> design/soft_knee_upward_compressor.sv
// Top level of the soft-knee upward compressor: configuration registers, front, queue and back.
//
// Per-channel upward compressor. Each transaction on upstream carries a
// signed sample and its channel; one transaction on downstream returns the
// boosted, saturated sample and the channel's smoothed boost in Q8.8 dB.
// The front end accepts a sample into a two-entry queue while it has room;
// the back end then works on one item at a time: 16 squaring steps for the
// log2 fraction, a 42-bit restoring divider for the ratio and knee
// quotient, and 16 steps raising the gain fraction to a power of two, all
// on one shared 32x32 multiplier. Zero and full-scale samples skip the
// squaring steps, and levels above the knee skip the divider. Configuration
// is written through cfg_we/cfg_index/cfg_data; the user must write it only
// while no item is in flight (the block does not enforce this). Envelopes reset to 0 dB.
module soft_knee_upward_compressor import skuc_pkg::*; #(
	parameter int CHANNELS    = CHANNELS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	skuc_in_if.sink               upstream,
	skuc_out_if.source            downstream
);

	skuc_cfg_t  cfg_q;
	skuc_item_t push_item;
	skuc_item_t pop_item;
	logic       push;
	logic       pop;
	logic       q_full;
	logic       q_empty;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ratio_q8      <= RATIO_RST;
			cfg_q.range_db      <= RANGE_RST;
			cfg_q.knee_db       <= KNEE_RST;
			cfg_q.attack_coeff  <= ATTACK_RST;
			cfg_q.release_coeff <= RELEASE_RST;
		end else if (cfg_we) begin
			case (skuc_reg_t'(cfg_index))
				REG_RATIO:   cfg_q.ratio_q8      <= cfg_data[RATIO_W-1:0];
				REG_RANGE:   cfg_q.range_db      <= cfg_data[DB_W-1:0];
				REG_KNEE:    cfg_q.knee_db       <= cfg_data[KNEE_W-1:0];
				REG_ATTACK:  cfg_q.attack_coeff  <= cfg_data[COEFF_W-1:0];
				REG_RELEASE: cfg_q.release_coeff <= cfg_data[COEFF_W-1:0];
				default: begin
				end
			endcase
		end
	end

	skuc_front #(
		.CHANNELS    (CHANNELS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.upstream (upstream),
		.q_full   (q_full),
		.push     (push),
		.item     (push_item)
	);

	skuc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item_in  (push_item),
		.full     (q_full),
		.pop      (pop),
		.empty    (q_empty),
		.item_out (pop_item)
	);

	skuc_back #(
		.CHANNELS    (CHANNELS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.empty      (q_empty),
		.item       (pop_item),
		.pop        (pop),
		.downstream (downstream)
	);

endmodule

>>> tb/skuc_checker.sv
// Checker for the soft-knee upward compressor: predicts each result and compares.
`timescale 1ns / 1ps

module skuc_checker import skuc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	skuc_in_if                    up,
	skuc_out_if                   dn,
	output int                    errors,
	output int                    pending
);

	typedef struct packed {
		logic [23:0]        sample;
		logic [BOOST_W-1:0] boost;
	} boosted_t;

	logic [RATIO_W-1:0]     ratio;
	logic signed [DB_W-1:0] range_thr;
	logic [KNEE_W-1:0]      knee;
	logic [COEFF_W-1:0]     attack;
	logic [COEFF_W-1:0]     release_c;
	logic [15:0]            env_db [2];
	logic [63:0]            root_tab [17];
	boosted_t               expected_q [$];

	function automatic logic [63:0] root64(input logic [63:0] x);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] b;
		v   = x;
		res = 0;
		b   = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v   = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// Level of a magnitude in Q8.8 dB, never above 0
	function automatic longint level_of(input logic [63:0] m);
		int          msb;
		logic [63:0] y;
		logic [63:0] frac;
		logic [63:0] neg_oct;
		logic [63:0] mag;
		msb  = 0;
		frac = 0;
		if (m == 0) return -25600;
		for (int i = 0; i < 24; i++) if (m[i]) msb = i;
		y = m << (30 - msb);
		for (int i = 15; i >= 0; i--) begin
			y = (y * y) >> 30;
			if (y >= (64'd1 << 31)) begin
				frac = frac | (64'd1 << i);
				y    = y >> 1;
			end
		end
		if (msb >= 23) return 0;
		neg_oct = (64'(23 - msb) << 16) - frac;
		mag     = (neg_oct * 64'd394566 + (64'd1 << 23)) >> 24;
		if (mag > 25600) mag = 25600;
		return -longint'(mag);
	endfunction

	function automatic longint boost_target(input longint lev);
		longint r;
		longint k;
		longint l2;
		longint lo2;
		longint hi2;
		longint t;
		longint x2;
		r   = (ratio < 256) ? 256 : longint'(ratio);
		k   = longint'(knee);
		l2  = 2 * lev;
		lo2 = 2 * longint'(range_thr) - k;
		hi2 = 2 * longint'(range_thr) + k;
		t   = 0;
		if (l2 < lo2) begin
			t = (longint'(range_thr) - lev) * (r - 256) / r;
		end else if (l2 < hi2 && k > 0) begin
			x2 = hi2 - l2;
			t  = (r - 256) * x2 * x2 / (8 * k * r);
		end
		if (t < 0) t = 0;
		if (t > 25600) t = 25600;
		return t;
	endfunction

	// Boost one sample against the smoothed envelope given; returns result and new envelope
	function automatic boosted_t boost_sample(input logic [23:0] s, input logic [63:0] env_in,
			output logic [63:0] env_out);
		boosted_t    res;
		logic        neg;
		logic [63:0] m;
		logic [63:0] tgt;
		logic [63:0] a;
		logic [63:0] env;
		logic [63:0] g;
		logic [63:0] mult;
		logic [63:0] r;
		int          sh;
		neg = s[23];
		m   = neg ? (64'd1 << 24) - 64'(s) : 64'(s);
		tgt = 64'(boost_target(level_of(m)));
		a   = (tgt > env_in) ? 64'(attack) : 64'(release_c);
		env = (a * env_in + (64'd65536 - a) * tgt + 64'd32768) >> 16;
		env_out = env;
		g    = (env * 64'd2786635 + 64'd32768) >> 16;
		mult = 64'd1 << 30;
		for (int k = 1; k <= 16; k++)
			if (g[16 - k]) mult = (mult * root_tab[k] + (64'd1 << 29)) >> 30;
		sh = 30 - int'(g >> 16);
		r  = (m * mult + (64'd1 << (sh - 1))) >> sh;
		if (neg) begin
			if (r > (64'd1 << 23)) r = 64'd1 << 23;
			res.sample = 24'((64'd1 << 24) - r);
		end else begin
			if (r > (64'd1 << 23) - 1) r = (64'd1 << 23) - 1;
			res.sample = r[23:0];
		end
		res.boost = env[BOOST_W-1:0];
		return res;
	endfunction

	initial begin
		root_tab[0] = 64'd1 << 31;
		for (int k = 1; k <= 16; k++) root_tab[k] = root64(root_tab[k - 1] << 30);
	end

	assign pending = expected_q.size();

	// Track registers, predict on input transactions, compare on output transactions
	always @(posedge clk or negedge arst_n) begin
		boosted_t    exp_r;
		logic [63:0] env_new;
		if (!arst_n) begin
			ratio     <= RATIO_RST;
			range_thr <= RANGE_RST;
			knee      <= KNEE_RST;
			attack    <= ATTACK_RST;
			release_c <= RELEASE_RST;
			env_db[0] <= 0;
			env_db[1] <= 0;
			errors    <= 0;
			expected_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_RATIO:   ratio     <= cfg_data[RATIO_W-1:0];
					REG_RANGE:   range_thr <= cfg_data;
					REG_KNEE:    knee      <= cfg_data[KNEE_W-1:0];
					REG_ATTACK:  attack    <= cfg_data;
					REG_RELEASE: release_c <= cfg_data;
					default: ;
				endcase
			end
			if (up.valid && up.ready) begin
				exp_r = boost_sample(up.sample_in, 64'(env_db[up.channel]), env_new);
				env_db[up.channel] <= env_new[15:0];
				expected_q.push_back(exp_r);
			end
			if (dn.valid && dn.ready) begin
				if (expected_q.size() == 0) begin
					$error("sample_out: result with no expected transaction, actual %0d",
						dn.sample_out);
					errors <= errors + 1;
				end else begin
					exp_r = expected_q.pop_front();
					if (dn.sample_out !== exp_r.sample || dn.boost_db !== exp_r.boost)
						errors <= errors + 1;
					if (dn.sample_out !== exp_r.sample)
						$error("sample_out: expected %0d, actual %0d",
							$signed(exp_r.sample), dn.sample_out);
					if (dn.boost_db !== exp_r.boost)
						$error("boost_db: expected %0d, actual %0d", exp_r.boost, dn.boost_db);
				end
			end
		end
	end

endmodule

>>> tb/tb_soft_knee_upward_compressor.sv
// Testbench top of the soft-knee upward compressor: stimulus, registers and verdict.
`timescale 1ns / 1ps

module tb_soft_knee_upward_compressor;
	import skuc_pkg::*;

	localparam int LIMIT    = 3000000;
	localparam int SETTLE   = 120;
	localparam int PHASES   = 8;
	localparam int PER_PHASE = 244;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    errors;
	int                    pending;
	int                    cycles;
	int                    burst_left;
	int                    gap_len;
	logic                  sending;

	skuc_in_if  #(.SAMPLE_BITS(24)) up_if ();
	skuc_out_if #(.SAMPLE_BITS(24)) dn_if ();

	soft_knee_upward_compressor #(.CHANNELS(2), .SAMPLE_BITS(24)) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.upstream   (up_if),
		.downstream (dn_if)
	);

	skuc_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.up        (up_if),
		.dn        (dn_if),
		.errors    (errors),
		.pending   (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// End the run on a hang
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb_soft_knee_upward_compressor: FAIL");
			$finish;
		end
	end

	// Stall the output side on a changing pattern: open, random, mostly closed, periodic
	initial begin
		int mode;
		int left;
		int tick;
		dn_if.ready <= 1'b0;
		mode = 0;
		left = 0;
		tick = 0;
		forever begin
			@(posedge clk);
			if (left == 0) begin
				mode = $urandom_range(3);
				left = $urandom_range(400, 20);
			end
			left--;
			tick++;
			case (mode)
				0: dn_if.ready <= 1'b1;
				1: dn_if.ready <= 1'($urandom_range(1));
				2: dn_if.ready <= ($urandom_range(7) == 0);
				default: dn_if.ready <= (tick % 5) < 2;
			endcase
		end
	end

	// Offer one transaction; valid stays high after acceptance unless a gap follows
	task automatic send_sample(input logic ch, input logic [23:0] s);
		if (burst_left == 0) begin
			burst_left = $urandom_range(24, 1);
			gap_len    = ($urandom_range(3) == 0) ? 0 : $urandom_range(15, 1);
			if (gap_len > 0 && sending) begin
				up_if.valid <= 1'b0;
				repeat (gap_len) @(posedge clk);
			end
		end
		burst_left--;
		up_if.valid     <= 1'b1;
		up_if.channel   <= ch;
		up_if.sample_in <= s;
		sending = 1'b1;
		do @(posedge clk); while (!up_if.ready);
	endtask

	// Drop valid and let the back end drain before touching registers
	task automatic drain();
		up_if.valid <= 1'b0;
		sending = 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Consecutive writes keep the enable high; caller lowers it
	task automatic write_reg(input skuc_reg_t idx, input logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	task automatic write_all(input logic [15:0] r, input logic [15:0] rg, input logic [15:0] k,
			input logic [15:0] at, input logic [15:0] rl);
		write_reg(REG_RATIO, r);
		write_reg(REG_RANGE, rg);
		write_reg(REG_KNEE, k);
		write_reg(REG_ATTACK, at);
		write_reg(REG_RELEASE, rl);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Random sample, spread over all levels from silence to full scale
	function automatic logic [23:0] rand_sample();
		logic [23:0] s;
		s = 24'($urandom);
		case ($urandom_range(9))
			0: return 24'h0;
			1: return 24'h7FFFFF;
			2: return 24'h800000;
			3: return -24'(1 << $urandom_range(22));
			default: return 24'($signed(s) >>> $urandom_range(23));
		endcase
	endfunction

	initial begin
		logic [23:0] directed [] = '{24'h000000, 24'h7FFFFF, 24'h800000, 24'hFFFFFF,
			24'h000001, 24'h000002, 24'h000100, 24'h000800, 24'h004000, 24'h020000,
			24'h400000, 24'hC00000, 24'hFFFF00, 24'h000053, 24'h800001, 24'h555555,
			24'hAAAAAA, 24'h001234, 24'h000000, 24'h7FFFFF};
		arst_n          = 1'b0;
		cfg_we          <= 1'b0;
		cfg_index       <= '0;
		cfg_data        <= '0;
		up_if.valid     <= 1'b0;
		up_if.channel   <= 1'b0;
		up_if.sample_in <= '0;
		burst_left = 0;
		gap_len    = 0;
		sending    = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Corner samples on both channels with reset settings
		foreach (directed[i]) send_sample(i[0], directed[i]);

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			case (ph)
				0: write_all(16'd256, 16'hD800, 16'd1536, 16'd0, 16'd0);
				1: write_all(16'd5120, 16'd0, 16'd6144, 16'd0, 16'd0);
				2: write_all(16'd5120, -16'sd25600, 16'd0, 16'd65535, 16'd65535);
				3: write_all(16'd100, 16'h7FFF, 16'd8191, 16'd30000, 16'd500);
				4: begin
					// Writes to unused indexes must be ignored
					cfg_we    <= 1'b1;
					cfg_index <= CFG_IDX_W'(5 + $urandom_range(2));
					cfg_data  <= 16'($urandom);
					@(posedge clk);
					write_all(16'hFFFF, 16'hC000, 16'd3000, 16'd60000, 16'd65000);
				end
				default: write_all(16'($urandom_range(5120, 256)),
					16'(-$urandom_range(25600)), 16'($urandom_range(6144)),
					16'($urandom), 16'($urandom));
			endcase
			for (int n = 0; n < PER_PHASE; n++)
				send_sample(1'($urandom_range(1)), rand_sample());
		end

		drain();
		if (errors == 0)
			$display("tb_soft_knee_upward_compressor: PASS");
		else
			$display("tb_soft_knee_upward_compressor: FAIL");
		$finish;
	end

endmodule

>>> sim.f
design/skuc_pkg.sv
design/skuc_stream_if.sv
design/skuc_front.sv
design/skuc_queue.sv
design/skuc_back.sv
design/soft_knee_upward_compressor.sv
tb/skuc_checker.sv
tb/tb_soft_knee_upward_compressor.sv
